// ===== design/stun_mp_pkg.sv =====
// ----------------------------------------------------------------------------
// STUN message parser package
// Payload types, record kinds, parse phases and attribute constants shared
// by the parser modules.
// ----------------------------------------------------------------------------
package stun_mp_pkg;

  localparam int unsigned NameCapDefault = 128;

  localparam int unsigned HdrCntWidth = 5;
  localparam logic [HdrCntWidth-1:0] HdrLastOffset = 5'd19;
  localparam logic [HdrCntWidth-1:0] TypeOffset = 5'd1;
  localparam logic [HdrCntWidth-1:0] FirstIdOffset = 5'd7;

  localparam int unsigned GatherWidth = 56;

  localparam logic [15:0] AttrMapped = 16'd1;
  localparam logic [15:0] AttrUser = 16'd6;
  localparam logic [15:0] AttrPass = 16'd7;
  localparam logic [7:0] FamilyIpv4 = 8'd1;

  typedef enum logic [3:0] {
    KIND_TYPE      = 4'd0,
    KIND_ID_WORD   = 4'd1,
    KIND_MAPPED    = 4'd2,
    KIND_USER_BYTE = 4'd3,
    KIND_PASS_BYTE = 4'd4,
    KIND_EMPTY     = 4'd5,
    KIND_UNKNOWN   = 4'd6,
    KIND_REJECTED  = 4'd7,
    KIND_TRUNCATED = 4'd8,
    KIND_TOO_SHORT = 4'd9,
    KIND_END       = 4'd10
  } record_kind_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_AHDR   = 2'd1,
    PH_VALUE  = 2'd2,
    PH_PAD    = 2'd3
  } parse_phase_e;

  typedef enum logic [1:0] {
    CLASS_SKIP   = 2'd0,
    CLASS_MAPPED = 2'd1,
    CLASS_USER   = 2'd2,
    CLASS_PASS   = 2'd3
  } attr_class_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  record_kind;
    logic [15:0] message_type;
    logic [31:0] value_word;
    logic [1:0]  word_index;
    logic [15:0] attr_type;
    logic [15:0] attr_size;
    logic [15:0] port;
    logic [7:0]  name_byte;
    logic        attr_end;
    logic        message_end;
  } out_item_t;

endpackage

// ===== design/stun_mp_in_stage.sv =====
// ----------------------------------------------------------------------------
// STUN parser input stage
// Registers one message byte and holds it until the parse step takes it.
// ----------------------------------------------------------------------------
module stun_mp_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  stun_mp_pkg::in_item_t in_data_i,
  input  logic                  take_i,
  output logic                  item_valid_o,
  output stun_mp_pkg::in_item_t item_o
);
  import stun_mp_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d = (in_valid_i && in_ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o = item_q;

endmodule

// ===== design/stun_mp_core.sv =====
// ----------------------------------------------------------------------------
// STUN parser core
// Holds the parse state and works out the record caused by one byte.
// ----------------------------------------------------------------------------
module stun_mp_core #(
  parameter int unsigned NameCap = stun_mp_pkg::NameCapDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  stun_mp_pkg::in_item_t  item_i,
  output logic                   rec_valid_o,
  output stun_mp_pkg::out_item_t rec_o
);
  import stun_mp_pkg::*;

  logic [HdrCntWidth-1:0] hdr_cnt_q, hdr_cnt_d;
  parse_phase_e           phase_q, phase_d;
  logic [15:0]            held_type_q, held_type_d;
  logic [15:0]            held_length_q, held_length_d;
  logic [15:0]            value_left_q, value_left_d;
  logic [1:0]             pad_left_q, pad_left_d;
  logic [GatherWidth-1:0] gather_q, gather_d;
  attr_class_e            class_q, class_d;

  logic [GatherWidth-1:0] gather_shift;
  logic [15:0]            ht, hl, vl_new;
  logic [1:0]             pad_new;
  logic [7:0]             b;
  logic                   last;
  logic                   has;
  record_kind_e           kind;
  out_item_t              rec;

  assign b = item_i.data_byte;
  assign last = item_i.last_byte;
  assign gather_shift = {gather_q[GatherWidth-9:0], b};

  always_comb begin
    hdr_cnt_d = hdr_cnt_q;
    phase_d = phase_q;
    held_type_d = held_type_q;
    held_length_d = held_length_q;
    value_left_d = value_left_q;
    pad_left_d = pad_left_q;
    gather_d = gather_q;
    class_d = class_q;
    ht = held_type_q;
    hl = held_length_q;
    vl_new = value_left_q;
    pad_new = pad_left_q;
    has = 1'b0;
    kind = KIND_END;
    rec = '0;

    case (phase_q)
      PH_HEADER: begin
        gather_d = gather_shift;
        if (hdr_cnt_q == TypeOffset) begin
          has = 1'b1;
          kind = KIND_TYPE;
          rec.message_type = gather_shift[15:0];
        end else if (hdr_cnt_q >= FirstIdOffset && hdr_cnt_q[1:0] == 2'b11) begin
          has = 1'b1;
          kind = KIND_ID_WORD;
          rec.value_word = gather_shift[31:0];
          rec.word_index = hdr_cnt_q[3:2] - 2'd1;
        end
        if (hdr_cnt_q == HdrLastOffset) begin
          phase_d = PH_AHDR;
          value_left_d = '0;
        end else begin
          hdr_cnt_d = hdr_cnt_q + 1'b1;
          if (last) begin
            has = 1'b1;
            kind = KIND_TOO_SHORT;
            rec.message_type = '0;
            rec.value_word = '0;
            rec.word_index = '0;
          end
        end
      end
      PH_AHDR: begin
        case (value_left_q[1:0])
          2'd0: begin
            ht = {b, 8'h00};
            hl = '0;
          end
          2'd1: ht = {held_type_q[15:8], b};
          2'd2: hl = {b, 8'h00};
          default: hl = {held_length_q[15:8], b};
        endcase
        held_type_d = ht;
        held_length_d = hl;
        if (value_left_q[1:0] != 2'd3) begin
          value_left_d = {14'd0, value_left_q[1:0]} + 16'd1;
        end else begin
          rec.attr_type = ht;
          rec.attr_size = hl;
          value_left_d = hl;
          pad_left_d = 2'd0 - hl[1:0];
          gather_d = '0;
          class_d = CLASS_SKIP;
          if (ht == AttrMapped) begin
            if (hl == 16'd8) begin
              class_d = CLASS_MAPPED;
            end else begin
              has = 1'b1;
              kind = KIND_REJECTED;
            end
          end else if (ht == AttrUser || ht == AttrPass) begin
            if (hl > 16'(NameCap)) begin
              has = 1'b1;
              kind = KIND_REJECTED;
            end else if (hl == 16'd0) begin
              has = 1'b1;
              kind = KIND_EMPTY;
            end else begin
              class_d = (ht == AttrUser) ? CLASS_USER : CLASS_PASS;
            end
          end else begin
            has = 1'b1;
            kind = KIND_UNKNOWN;
          end
          phase_d = (hl != 16'd0) ? PH_VALUE : PH_AHDR;
        end
        if (last) begin
          if (value_left_q[1:0] != 2'd3 || hl != 16'd0) begin
            has = 1'b1;
            kind = KIND_TRUNCATED;
            rec.attr_type = ht;
            rec.attr_size = hl;
          end else if (!has) begin
            has = 1'b1;
            kind = KIND_END;
          end
        end
      end
      PH_VALUE: begin
        gather_d = gather_shift;
        if (value_left_q != 16'd0) begin
          vl_new = value_left_q - 16'd1;
        end
        value_left_d = vl_new;
        rec.attr_type = held_type_q;
        rec.attr_size = held_length_q;
        if (class_q == CLASS_USER || class_q == CLASS_PASS) begin
          has = 1'b1;
          kind = (class_q == CLASS_USER) ? KIND_USER_BYTE : KIND_PASS_BYTE;
          rec.name_byte = b;
          rec.attr_end = (vl_new == 16'd0);
        end else if (class_q == CLASS_MAPPED && vl_new == 16'd0) begin
          has = 1'b1;
          if (gather_shift[55:48] == FamilyIpv4) begin
            kind = KIND_MAPPED;
            rec.port = gather_shift[47:32];
            rec.value_word = gather_shift[31:0];
          end else begin
            kind = KIND_REJECTED;
          end
        end
        if (vl_new == 16'd0) begin
          phase_d = (pad_left_q != 2'd0) ? PH_PAD : PH_AHDR;
        end
        if (last) begin
          if (vl_new != 16'd0) begin
            has = 1'b1;
            kind = KIND_TRUNCATED;
            rec.port = '0;
            rec.value_word = '0;
            rec.name_byte = '0;
            rec.attr_end = 1'b0;
          end else if (!has) begin
            has = 1'b1;
            kind = KIND_END;
          end
        end
      end
      default: begin
        pad_new = pad_left_q - 2'd1;
        pad_left_d = pad_new;
        if (pad_new == 2'd0) begin
          phase_d = PH_AHDR;
          value_left_d = '0;
        end
        if (last) begin
          has = 1'b1;
          kind = KIND_END;
        end
      end
    endcase

    if (last) begin
      hdr_cnt_d = '0;
      phase_d = PH_HEADER;
      held_type_d = '0;
      held_length_d = '0;
      value_left_d = '0;
      pad_left_d = '0;
      gather_d = '0;
      class_d = CLASS_SKIP;
    end

    rec.record_kind = kind;
    rec.message_end = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_cnt_q <= '0;
      phase_q <= PH_HEADER;
      held_type_q <= '0;
      held_length_q <= '0;
      value_left_q <= '0;
      pad_left_q <= '0;
      gather_q <= '0;
      class_q <= CLASS_SKIP;
    end else if (step_i) begin
      hdr_cnt_q <= hdr_cnt_d;
      phase_q <= phase_d;
      held_type_q <= held_type_d;
      held_length_q <= held_length_d;
      value_left_q <= value_left_d;
      pad_left_q <= pad_left_d;
      gather_q <= gather_d;
      class_q <= class_d;
    end
  end

  assign rec_valid_o = has;
  assign rec_o = rec;

endmodule

// ===== design/stun_mp_out_stage.sv =====
// ----------------------------------------------------------------------------
// STUN parser output stage
// Result register that holds one record until the consumer takes it.
// ----------------------------------------------------------------------------
module stun_mp_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   item_valid_i,
  output logic                   take_o,
  input  logic                   rec_valid_i,
  input  stun_mp_pkg::out_item_t rec_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output stun_mp_pkg::out_item_t out_data_o
);
  import stun_mp_pkg::*;

  logic      valid_q, valid_d;
  out_item_t rec_q;

  assign take_o = item_valid_i && (!valid_q || out_ready_i);
  assign valid_d = take_o ? rec_valid_i : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && rec_valid_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o = rec_q;

endmodule

// ===== design/stun_message_parser.sv =====
// ----------------------------------------------------------------------------
// STUN message parser
// Parses a STUN message arriving one byte per request into header, id word,
// address, name byte and status records.
// A byte is held in the input register, and the record it causes, if any, in the result register.
// Throughput: one byte per cycle while the result register is not stalled, set by the single
// parse step between the input register and the result register.
// Reset clears the parse state to the start of a message and empties both
// registers.
// ----------------------------------------------------------------------------
module stun_message_parser #(
  parameter int unsigned NameCap = stun_mp_pkg::NameCapDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  stun_mp_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output stun_mp_pkg::out_item_t out_data_o
);
  import stun_mp_pkg::*;

  logic      item_valid;
  logic      take;
  logic      rec_valid;
  in_item_t  item;
  out_item_t rec;

  stun_mp_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  stun_mp_core #(
    .NameCap (NameCap)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (take),
    .item_i      (item),
    .rec_valid_o (rec_valid),
    .rec_o       (rec)
  );

  stun_mp_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .take_o       (take),
    .rec_valid_i  (rec_valid),
    .rec_i        (rec),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
